### rtl/core/dsdr_pkg.sv
// Shared types, constants and state encoding for the send descriptor ring.
package dsdr_pkg;

	localparam logic [31:0] END_BIT      = 32'h8000_0000;
	localparam logic [31:0] DEST_TAG     = 32'h1000_0000;
	localparam logic [31:0] DEST_TAG_END = 32'h9000_0000;
	localparam logic [31:0] PHYS_MASK    = 32'h1FFF_FFFF;
	localparam logic [15:0] QUAD_MAX     = 16'hFFFF;

	localparam logic CMD_QUEUE  = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_BLOCK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_WRITE,
		ST_LOAD,
		ST_EMIT,
		ST_STATUS
	} state_t;

	// One formatted send block as kept in the ring.
	typedef struct packed {
		logic [31:0] address;
		logic [17:0] words;
		logic [31:0] tag;
		logic [28:0] destination;
	} blk_word_t;

	// Per-group bookkeeping.
	typedef struct packed {
		logic [1:0]  run_length;
		logic        want;
		logic [15:0] tag;
	} grp_word_t;

	// Controller to datapath.
	typedef struct packed {
		logic capture;
		logic write_blk;
		logic commit;
		logic retire;
		logic blk_inc;
		logic emit_blk;
		logic emit_status;
	} ctl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_finish;
		logic run_ok;
		logic full;
		logic empty;
		logic one_left;
		logic last_write;
		logic last_emit;
	} dp_sts_t;

endpackage

### rtl/core/dma_send_descriptor_ring.sv
// Top level of the send descriptor ring: controller plus datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------------
//  item    | in        | start && !busy       | cmd, run_length, transfer a/b fields,
//          |           |                      | want_notify, notify_tag
//  result  | out       | strobe (one cycle)   | kind, accepted, busy_res, done_valid,
//          |           |                      | done_tag, blk_* fields, last
//
// One item at a time. An item that is refused or ignored goes straight to status.
// A run of n transfers queued behind a busy channel writes its blocks (one ring
// memory write per block), then status. A finished event that starts the next
// group of n blocks reads the ring and emits each block, then status. A run of n
// transfers starting an idle channel writes each block, reads the ring, emits each, then status.
// Results leave one per cycle on the single result port and cannot be stalled;
// busy stays high until the status item (last = 1) has gone out.
// Reset clears the pointers, block counter, result flags and controller only;
// ring contents start unknown, are read only once written, and need no clearing pass.
module dma_send_descriptor_ring #(
	parameter int RING_GROUPS = 32,
	parameter int RUN_BLOCKS  = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [1:0]  run_length,
	input  logic [31:0] src_a,
	input  logic [19:0] bytes_a,
	input  logic [31:0] dest_a,
	input  logic        end_remote_a,
	input  logic [31:0] src_b,
	input  logic [19:0] bytes_b,
	input  logic [31:0] dest_b,
	input  logic        end_remote_b,
	input  logic        want_notify,
	input  logic [15:0] notify_tag,
	output logic        strobe,
	output logic        kind,
	output logic        accepted,
	output logic        busy_res,
	output logic        done_valid,
	output logic [15:0] done_tag,
	output logic [31:0] blk_address,
	output logic [17:0] blk_words,
	output logic [31:0] blk_tag,
	output logic [28:0] blk_destination,
	output logic        last
);

	// command and status between sequencer and datapath
	dsdr_pkg::ctl_cmd_t ctl_cmd;
	dsdr_pkg::dp_sts_t  dp_sts;

	// Sequencer: decode, write the run, retire, emit blocks, report status.
	dsdr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (dp_sts),
		.cmd    (ctl_cmd)
	);

	// Datapath: hold the item, format blocks into the ring, drive the result port.
	dsdr_dp #(
		.RING_GROUPS (RING_GROUPS),
		.RUN_BLOCKS  (RUN_BLOCKS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (ctl_cmd),
		.sts             (dp_sts),
		.cmd_in          (cmd),
		.run_length      (run_length),
		.src_a           (src_a),
		.bytes_a         (bytes_a),
		.dest_a          (dest_a),
		.end_remote_a    (end_remote_a),
		.src_b           (src_b),
		.bytes_b         (bytes_b),
		.dest_b          (dest_b),
		.end_remote_b    (end_remote_b),
		.want_notify     (want_notify),
		.notify_tag      (notify_tag),
		.strobe          (strobe),
		.kind            (kind),
		.accepted        (accepted),
		.busy_res        (busy_res),
		.done_valid      (done_valid),
		.done_tag        (done_tag),
		.blk_address     (blk_address),
		.blk_words       (blk_words),
		.blk_tag         (blk_tag),
		.blk_destination (blk_destination),
		.last            (last)
	);

endmodule

### rtl/core/dsdr_ctrl.sv
// Sequencing state machine for the send descriptor ring.
module dsdr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  dsdr_pkg::dp_sts_t  sts,
	output dsdr_pkg::ctl_cmd_t cmd
);

	dsdr_pkg::state_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsdr_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			dsdr_pkg::ST_IDLE: begin
				if (start) state_next = dsdr_pkg::ST_DECODE;
			end
			dsdr_pkg::ST_DECODE: begin
				if (sts.is_finish) begin
					if (sts.empty || sts.one_left) state_next = dsdr_pkg::ST_STATUS;
					else state_next = dsdr_pkg::ST_LOAD;
				end else begin
					if (!sts.run_ok || sts.full) state_next = dsdr_pkg::ST_STATUS;
					else state_next = dsdr_pkg::ST_WRITE;
				end
			end
			dsdr_pkg::ST_WRITE: begin
				// channel was idle: start it on the group just written
				if (sts.last_write) begin
					if (sts.empty) state_next = dsdr_pkg::ST_LOAD;
					else state_next = dsdr_pkg::ST_STATUS;
				end
			end
			dsdr_pkg::ST_LOAD: begin
				state_next = dsdr_pkg::ST_EMIT;
			end
			dsdr_pkg::ST_EMIT: begin
				if (sts.last_emit) state_next = dsdr_pkg::ST_STATUS;
			end
			dsdr_pkg::ST_STATUS: begin
				state_next = dsdr_pkg::ST_IDLE;
			end
			default: begin
				state_next = dsdr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			dsdr_pkg::ST_IDLE: begin
				busy        = 1'b0;
				cmd.capture = start;
			end
			dsdr_pkg::ST_DECODE: begin
				cmd.retire = sts.is_finish && !sts.empty;
			end
			dsdr_pkg::ST_WRITE: begin
				cmd.write_blk = 1'b1;
				cmd.commit    = sts.last_write;
			end
			dsdr_pkg::ST_LOAD: begin
				cmd = '0;
			end
			dsdr_pkg::ST_EMIT: begin
				cmd.emit_blk = 1'b1;
				cmd.blk_inc  = 1'b1;
			end
			dsdr_pkg::ST_STATUS: begin
				cmd.emit_status = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

### rtl/core/dsdr_dp.sv
// Datapath of the send descriptor ring: input latches, ring memories, pointers, result mux.
module dsdr_dp #(
	parameter int RING_GROUPS = 32,
	parameter int RUN_BLOCKS  = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dsdr_pkg::ctl_cmd_t cmd,
	output dsdr_pkg::dp_sts_t  sts,
	input  logic               cmd_in,
	input  logic [1:0]         run_length,
	input  logic [31:0]        src_a,
	input  logic [19:0]        bytes_a,
	input  logic [31:0]        dest_a,
	input  logic               end_remote_a,
	input  logic [31:0]        src_b,
	input  logic [19:0]        bytes_b,
	input  logic [31:0]        dest_b,
	input  logic               end_remote_b,
	input  logic               want_notify,
	input  logic [15:0]        notify_tag,
	output logic               strobe,
	output logic               kind,
	output logic               accepted,
	output logic               busy_res,
	output logic               done_valid,
	output logic [15:0]        done_tag,
	output logic [31:0]        blk_address,
	output logic [17:0]        blk_words,
	output logic [31:0]        blk_tag,
	output logic [28:0]        blk_destination,
	output logic               last
);

	localparam int GAW    = (RING_GROUPS > 1) ? $clog2(RING_GROUPS) : 1;
	localparam int QW     = $clog2(RING_GROUPS + 1);
	localparam int BDEPTH = RING_GROUPS * RUN_BLOCKS;
	localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam logic [GAW:0]   RING_W    = (GAW + 1)'(RING_GROUPS);
	localparam logic [GAW-1:0] HEAD_LAST = GAW'(RING_GROUPS - 1);
	localparam logic [QW-1:0]  RING_FULL = QW'(RING_GROUPS);
	localparam logic [1:0]     RB_CODE   = 2'(RUN_BLOCKS);

	// latched item
	logic        cmd_q;
	logic [1:0]  run_len_q;
	logic [31:0] src_a_q, src_b_q, dest_a_q, dest_b_q;
	logic [19:0] bytes_a_q, bytes_b_q;
	logic        end_a_q, end_b_q, want_q;
	logic [15:0] tag_q;

	// control state
	logic [GAW-1:0] head_q;
	logic [QW-1:0]  queued_q;
	logic           blk_q;
	logic           acc_q;
	logic           dv_q;
	logic [15:0]    dtag_q;

	// memories
	dsdr_pkg::blk_word_t blk_mem [BDEPTH];
	dsdr_pkg::grp_word_t grp_mem [RING_GROUPS];
	dsdr_pkg::blk_word_t blk_rd_q;
	dsdr_pkg::grp_word_t grp_rd_q;

	logic [GAW:0]        slot_sum;
	logic [GAW-1:0]      slot;
	logic [BAW-1:0]      wr_addr, rd_addr;
	logic                rd_blk;
	logic                wr_last;
	dsdr_pkg::blk_word_t wr_word;
	dsdr_pkg::grp_word_t grp_word;
	logic [19:0]         sel_bytes;
	logic [31:0]         sel_src, sel_dest;
	logic                sel_end;
	logic [20:0]         bytes_up;
	logic [18:0]         words_up;
	logic [16:0]         quads_raw;
	logic [15:0]         quads;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q     <= cmd_in;
			run_len_q <= run_length;
			src_a_q   <= src_a;
			bytes_a_q <= bytes_a;
			dest_a_q  <= dest_a;
			end_a_q   <= end_remote_a;
			src_b_q   <= src_b;
			bytes_b_q <= bytes_b;
			dest_b_q  <= dest_b;
			end_b_q   <= end_remote_b;
			want_q    <= want_notify;
			tag_q     <= notify_tag;
		end
	end

	// Write slot: one past the newest group, modulo the ring size.
	always_comb begin
		slot_sum = (GAW + 1)'(head_q) + (GAW + 1)'(queued_q);
		if (slot_sum >= RING_W) slot = GAW'(slot_sum - RING_W);
		else slot = GAW'(slot_sum);
	end

	assign wr_addr = BAW'(slot) * BAW'(RUN_BLOCKS) + BAW'(blk_q);
	assign rd_blk  = cmd.blk_inc ? ~blk_q : blk_q;
	assign rd_addr = BAW'(head_q) * BAW'(RUN_BLOCKS) + BAW'(rd_blk);
	assign wr_last = ({1'b0, blk_q} + 2'd1) == run_len_q;

	// Format the transfer selected by the block counter.
	always_comb begin
		sel_src   = blk_q ? src_b_q : src_a_q;
		sel_bytes = blk_q ? bytes_b_q : bytes_a_q;
		sel_dest  = blk_q ? dest_b_q : dest_a_q;
		sel_end   = blk_q ? end_b_q : end_a_q;
		bytes_up  = {1'b0, sel_bytes} + 21'd3;
		words_up  = bytes_up[20:2];
		quads_raw = 17'(({1'b0, words_up} + 20'd3) >> 2);
		quads     = quads_raw[16] ? dsdr_pkg::QUAD_MAX : quads_raw[15:0];
		wr_word.address     = sel_src | (wr_last ? dsdr_pkg::END_BIT : 32'd0);
		wr_word.words       = {quads, 2'b00};
		wr_word.tag         = ((wr_last && sel_end) ? dsdr_pkg::DEST_TAG_END
			: dsdr_pkg::DEST_TAG) | {16'd0, quads};
		wr_word.destination = sel_dest[28:0] & dsdr_pkg::PHYS_MASK[28:0];
		grp_word.run_length = run_len_q;
		grp_word.want       = want_q;
		grp_word.tag        = tag_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.write_blk) blk_mem[wr_addr] <= wr_word;
		blk_rd_q <= blk_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.write_blk && !blk_q) grp_mem[slot] <= grp_word;
		grp_rd_q <= grp_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			queued_q <= '0;
			blk_q    <= 1'b0;
			acc_q    <= 1'b0;
			dv_q     <= 1'b0;
			dtag_q   <= '0;
		end else begin
			if (cmd.capture) begin
				blk_q  <= 1'b0;
				acc_q  <= 1'b0;
				dv_q   <= 1'b0;
				dtag_q <= '0;
			end
			if (cmd.write_blk && !cmd.commit) blk_q <= ~blk_q;
			if (cmd.blk_inc) blk_q <= ~blk_q;
			if (cmd.commit) begin
				queued_q <= queued_q + QW'(1);
				acc_q    <= 1'b1;
				blk_q    <= 1'b0;
			end
			if (cmd.retire) begin
				head_q   <= (head_q == HEAD_LAST) ? '0 : head_q + GAW'(1);
				queued_q <= queued_q - QW'(1);
				dv_q     <= grp_rd_q.want;
				dtag_q   <= grp_rd_q.want ? grp_rd_q.tag : 16'd0;
			end
		end
	end

	always_comb begin
		sts.is_finish  = cmd_q == dsdr_pkg::CMD_FINISH;
		sts.run_ok     = (run_len_q != 2'd0) && (run_len_q <= RB_CODE);
		sts.full       = queued_q == RING_FULL;
		sts.empty      = queued_q == '0;
		sts.one_left   = queued_q == QW'(1);
		sts.last_write = wr_last;
		sts.last_emit  = ({1'b0, blk_q} + 2'd1) == grp_rd_q.run_length;
	end

	always_comb begin
		strobe          = cmd.emit_blk || cmd.emit_status;
		kind            = dsdr_pkg::KIND_STATUS;
		accepted        = 1'b0;
		busy_res        = 1'b0;
		done_valid      = 1'b0;
		done_tag        = '0;
		blk_address     = '0;
		blk_words       = '0;
		blk_tag         = '0;
		blk_destination = '0;
		last            = 1'b0;
		if (cmd.emit_blk) begin
			kind            = dsdr_pkg::KIND_BLOCK;
			blk_address     = blk_rd_q.address;
			blk_words       = blk_rd_q.words;
			blk_tag         = blk_rd_q.tag;
			blk_destination = blk_rd_q.destination;
		end else if (cmd.emit_status) begin
			accepted   = acc_q;
			busy_res   = queued_q != '0;
			done_valid = dv_q;
			done_tag   = dtag_q;
			last       = 1'b1;
		end
	end

endmodule

### rtl/core/dsdr_chk.sv
// Port-level checks for the send descriptor ring, bound to the top level.
module dsdr_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        strobe,
	input logic        kind,
	input logic        accepted,
	input logic        busy_res,
	input logic        done_valid,
	input logic [15:0] done_tag,
	input logic        last
);

	a_take_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item taken but block not busy");

	a_no_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !strobe)
		else $error("result while idle");

	a_status_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !busy && !strobe)
		else $error("block still busy after status item");

	a_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (kind != last))
		else $error("status item must be last and only last");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last && accepted |-> busy_res && !done_valid && done_tag == 16'd0)
		else $error("accepted run with ring reported empty or a tag");

endmodule

bind dma_send_descriptor_ring dsdr_chk u_dsdr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.strobe     (strobe),
	.kind       (kind),
	.accepted   (accepted),
	.busy_res   (busy_res),
	.done_valid (done_valid),
	.done_tag   (done_tag),
	.last       (last)
);
